// ===== hdl/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed port widths
    localparam int FUNC_W    = 3;
    localparam int KEY_IN_W  = 32;
    localparam int IDX_W     = 6;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT   = 3'd0,
        FN_INS_UNIQ = 3'd1,
        FN_FIND     = 3'd2,
        FN_READ     = 3'd3,
        FN_DEL_IDX  = 3'd4,
        FN_DEL_KEY  = 3'd5,
        FN_DEL_ALL  = 3'd6
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_DUPLICATE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_DATA,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS_RD,
        S_INS_WR,
        S_RESP
    } state_t;

    // stored key vs. operand key
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_t;

    typedef struct packed {
        status_t                status;
        logic [IDX_W-1:0]       fidx;
        logic [KEY_IN_W-1:0]    key;
        logic [CNT_OUT_W-1:0]   count;
    } res_t;

endpackage

// ===== hdl/skt_key_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_key_mem
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_key_mem #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF,
    parameter int KEY_W = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [KEY_W-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [KEY_W-1:0]         rd_data
);

    logic [KEY_W-1:0] store_mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/skt_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cmp
// Shared unsigned key comparator used by every search and scan step and by the insert shift.
// ----------------------------------------------------------------------------
module skt_cmp #(
    parameter int KEY_W = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic [KEY_W-1:0] stored,
    input  logic [KEY_W-1:0] operand,
    output skt_pkg::cmp_t    result
);

    always_comb
    begin
        result.eq = (stored == operand);
        result.gt = (stored > operand);
    end

endmodule

// ===== hdl/skt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: binary search, run scan, insert shift and delete shift, one
// memory access per step, plus one compare in the search, scan and insert steps.
// ----------------------------------------------------------------------------
module skt_ctrl #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF,
    parameter int KEY_W = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [skt_pkg::FUNC_W-1:0]    func,
    input  logic [skt_pkg::KEY_IN_W-1:0]  key,
    input  logic [skt_pkg::IDX_W-1:0]     index,
    // memory
    output logic                          mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
    output logic [KEY_W-1:0]              mem_wr_data,
    output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
    input  logic [KEY_W-1:0]              mem_rd_data,
    // result
    output logic                          res_valid,
    output skt_pkg::res_t                 res,
    input  logic                          res_take
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = skt_pkg::IDX_W;

    skt_pkg::state_t  state_reg,  state_next;
    skt_pkg::func_t   func_reg,   func_next;
    skt_pkg::status_t status_reg, status_next;
    logic [KEY_W-1:0] key_reg,    key_next;
    logic [IW-1:0]    idx_reg,    idx_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    pos_reg,    pos_next;   // probe / first deleted index
    logic [CW-1:0]    a_reg,      a_next;     // search low, insert slot, dst
    logic [CW-1:0]    b_reg,      b_next;     // search high (excl), run end, src
    logic [CW-1:0]    fidx_reg,   fidx_next;
    logic [KEY_W-1:0] kout_reg,   kout_next;

    skt_pkg::cmp_t    cmp;
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid;
    logic [CW+IW-1:0] idx_x;
    logic [CW+IW-1:0] cnt_x;
    logic             idx_bad;
    logic [CW-1:0]    idx_ptr;
    logic             full;

    skt_cmp #(
        .KEY_W (KEY_W)
    ) u_cmp (
        .stored  (mem_rd_data),
        .operand (key_reg),
        .result  (cmp)
    );

    assign mid_sum = {1'b0, a_reg} + {1'b0, b_reg} - (CW+1)'(1);
    assign mid     = mid_sum[CW:1];
    assign idx_x   = {{CW{1'b0}}, idx_reg};
    assign cnt_x   = {{IW{1'b0}}, count_reg};
    assign idx_bad = (idx_x >= cnt_x);
    assign idx_ptr = idx_x[CW-1:0];
    assign full    = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        fidx_reg   <= fidx_next;
        kout_reg   <= kout_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        status_next = status_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        fidx_next   = fidx_reg;
        kout_next   = kout_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = a_reg[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_addr = '0;
        in_stall    = (state_reg != skt_pkg::S_IDLE);
        res_valid   = 1'b0;

        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = skt_pkg::func_t'(func);
                    key_next    = key[KEY_W-1:0];
                    idx_next    = index;
                    status_next = skt_pkg::ST_OK;
                    fidx_next   = '0;
                    kout_next   = '0;
                    state_next  = skt_pkg::S_DISPATCH;
                end
            end

            skt_pkg::S_DISPATCH:
            begin
                unique case (func_reg)
                    skt_pkg::FN_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = skt_pkg::ST_FULL;
                            state_next  = skt_pkg::S_RESP;
                        end
                        else
                        begin
                            a_next     = count_reg;
                            state_next = skt_pkg::S_INS_RD;
                        end
                    end
                    skt_pkg::FN_INS_UNIQ, skt_pkg::FN_FIND,
                    skt_pkg::FN_DEL_KEY, skt_pkg::FN_DEL_ALL:
                    begin
                        a_next     = '0;
                        b_next     = count_reg;
                        state_next = skt_pkg::S_SRCH_RD;
                    end
                    skt_pkg::FN_READ:
                    begin
                        if (idx_bad)
                        begin
                            status_next = skt_pkg::ST_BAD_INDEX;
                            state_next  = skt_pkg::S_RESP;
                        end
                        else
                        begin
                            mem_rd_addr = idx_ptr[AW-1:0];
                            state_next  = skt_pkg::S_READ_DATA;
                        end
                    end
                    skt_pkg::FN_DEL_IDX:
                    begin
                        if (idx_bad)
                        begin
                            status_next = skt_pkg::ST_BAD_INDEX;
                            state_next  = skt_pkg::S_RESP;
                        end
                        else
                        begin
                            pos_next   = idx_ptr;
                            a_next     = idx_ptr;
                            b_next     = idx_ptr + CW'(1);
                            state_next = skt_pkg::S_SH_RD;
                        end
                    end
                    default:
                    begin
                        // unused code: empty ok result
                        state_next = skt_pkg::S_RESP;
                    end
                endcase
            end

            skt_pkg::S_READ_DATA:
            begin
                kout_next  = mem_rd_data;
                fidx_next  = idx_ptr;
                state_next = skt_pkg::S_RESP;
            end

            // binary search over [a, b)
            skt_pkg::S_SRCH_RD:
            begin
                if (a_reg < b_reg)
                begin
                    pos_next    = mid;
                    mem_rd_addr = mid[AW-1:0];
                    state_next  = skt_pkg::S_SRCH_CMP;
                end
                else if (func_reg == skt_pkg::FN_INS_UNIQ)
                begin
                    if (full)
                    begin
                        status_next = skt_pkg::ST_FULL;
                        state_next  = skt_pkg::S_RESP;
                    end
                    else
                    begin
                        a_next     = count_reg;
                        state_next = skt_pkg::S_INS_RD;
                    end
                end
                else
                begin
                    status_next = skt_pkg::ST_NOT_FOUND;
                    state_next  = skt_pkg::S_RESP;
                end
            end

            skt_pkg::S_SRCH_CMP:
            begin
                if (cmp.eq)
                begin
                    unique case (func_reg)
                        skt_pkg::FN_INS_UNIQ:
                        begin
                            status_next = skt_pkg::ST_DUPLICATE;
                            state_next  = skt_pkg::S_RESP;
                        end
                        skt_pkg::FN_DEL_KEY:
                        begin
                            a_next     = pos_reg;
                            b_next     = pos_reg + CW'(1);
                            state_next = skt_pkg::S_SH_RD;
                        end
                        skt_pkg::FN_DEL_ALL:
                        begin
                            b_next     = pos_reg + CW'(1);
                            state_next = skt_pkg::S_DN_RD;
                        end
                        default:
                        begin
                            fidx_next  = pos_reg;
                            state_next = skt_pkg::S_RESP;
                        end
                    endcase
                end
                else if (cmp.gt)
                begin
                    b_next     = pos_reg;
                    state_next = skt_pkg::S_SRCH_RD;
                end
                else
                begin
                    a_next     = pos_reg + CW'(1);
                    state_next = skt_pkg::S_SRCH_RD;
                end
            end

            // walk down to the first equal key
            skt_pkg::S_DN_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = skt_pkg::S_UP_RD;
                end
                else
                begin
                    mem_rd_addr = AW'(pos_reg - CW'(1));
                    state_next  = skt_pkg::S_DN_CMP;
                end
            end

            skt_pkg::S_DN_CMP:
            begin
                if (cmp.eq)
                begin
                    pos_next   = pos_reg - CW'(1);
                    state_next = skt_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = skt_pkg::S_UP_RD;
                end
            end

            // walk up to the end of the equal run
            skt_pkg::S_UP_RD:
            begin
                if (b_reg >= count_reg)
                begin
                    a_next     = pos_reg;
                    state_next = skt_pkg::S_SH_RD;
                end
                else
                begin
                    mem_rd_addr = b_reg[AW-1:0];
                    state_next  = skt_pkg::S_UP_CMP;
                end
            end

            skt_pkg::S_UP_CMP:
            begin
                if (cmp.eq)
                begin
                    b_next     = b_reg + CW'(1);
                    state_next = skt_pkg::S_UP_RD;
                end
                else
                begin
                    a_next     = pos_reg;
                    state_next = skt_pkg::S_SH_RD;
                end
            end

            // close the gap: copy [b, count) down to a; final a is new count
            skt_pkg::S_SH_RD:
            begin
                if (b_reg >= count_reg)
                begin
                    count_next = a_reg;
                    fidx_next  = pos_reg;
                    state_next = skt_pkg::S_RESP;
                end
                else
                begin
                    mem_rd_addr = b_reg[AW-1:0];
                    state_next  = skt_pkg::S_SH_WR;
                end
            end

            skt_pkg::S_SH_WR:
            begin
                mem_wr_en  = 1'b1;
                a_next     = a_reg + CW'(1);
                b_next     = b_reg + CW'(1);
                state_next = skt_pkg::S_SH_RD;
            end

            // insertion from the top: move larger-or-equal keys up one slot
            skt_pkg::S_INS_RD:
            begin
                if (a_reg == '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = key_reg;
                    fidx_next   = '0;
                    count_next  = count_reg + CW'(1);
                    state_next  = skt_pkg::S_RESP;
                end
                else
                begin
                    mem_rd_addr = AW'(a_reg - CW'(1));
                    state_next  = skt_pkg::S_INS_WR;
                end
            end

            skt_pkg::S_INS_WR:
            begin
                mem_wr_en = 1'b1;
                if (cmp.eq || cmp.gt)
                begin
                    a_next     = a_reg - CW'(1);
                    state_next = skt_pkg::S_INS_RD;
                end
                else
                begin
                    mem_wr_data = key_reg;
                    fidx_next   = a_reg;
                    count_next  = count_reg + CW'(1);
                    state_next  = skt_pkg::S_RESP;
                end
            end

            skt_pkg::S_RESP:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    logic [CW+IW-1:0]                     fidx_x;
    logic [KEY_W+skt_pkg::KEY_IN_W-1:0]   kout_x;
    logic [CW+skt_pkg::CNT_OUT_W-1:0]     cnt_out_x;

    assign fidx_x    = {{IW{1'b0}}, fidx_reg};
    assign kout_x    = {{skt_pkg::KEY_IN_W{1'b0}}, kout_reg};
    assign cnt_out_x = {{skt_pkg::CNT_OUT_W{1'b0}}, count_reg};

    always_comb
    begin
        res.status = status_reg;
        res.fidx   = fidx_x[IW-1:0];
        res.key    = kout_x[skt_pkg::KEY_IN_W-1:0];
        res.count  = cnt_out_x[skt_pkg::CNT_OUT_W-1:0];
    end

endmodule

// ===== hdl/sorted_key_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Sorted table of up to DEPTH unsigned keys with insert, find, read and delete.
// ----------------------------------------------------------------------------
// Holds up to DEPTH keys in ascending order in a single-port-read,
// single-port-write memory. One request transfer is taken at a time; in_stall
// stays high from acceptance until the result has moved into the output
// register, and a new request can be taken while that result still waits for
// its output transfer. Each step of the sequencer does at most one memory
// access, and the search, scan and insert shift steps also compare in the
// shared comparator, so the key memory sets the pace. With n keys held, find
// takes up to floor(log2(n))+1 probes; insert moves the keys at and above its
// position p up one slot (insert unique after its search); delete index and
// delete key copy the keys above the gap down one slot; delete all first
// scans the run of equal keys. The key store has no reset; only entries
// below the key count are ever used.
// ----------------------------------------------------------------------------
module sorted_key_table_core #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [skt_pkg::FUNC_W-1:0]       func,
    input  logic [skt_pkg::KEY_IN_W-1:0]     key,
    input  logic [skt_pkg::IDX_W-1:0]        index,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [skt_pkg::STAT_W-1:0]       status,
    output logic [skt_pkg::IDX_W-1:0]        found_index,
    output logic [skt_pkg::KEY_IN_W-1:0]     key_out,
    output logic [skt_pkg::CNT_OUT_W-1:0]    entry_count_out
);

    // keys wider than the key port never see more than the port's bits
    localparam int KW = (KEY_WIDTH < skt_pkg::KEY_IN_W) ? KEY_WIDTH : skt_pkg::KEY_IN_W;
    localparam int AW = $clog2(DEPTH);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [KW-1:0] mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [KW-1:0] mem_rd_data;

    logic          res_valid;
    logic          res_take;
    skt_pkg::res_t res;

    logic          out_valid_reg, out_valid_next;
    skt_pkg::res_t out_reg;

    skt_key_mem #(
        .DEPTH (DEPTH),
        .KEY_W (KW)
    ) u_key_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    skt_ctrl #(
        .DEPTH (DEPTH),
        .KEY_W (KW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .index       (index),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    // output register: load when empty or when its transfer happens now
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign found_index     = out_reg.fidx;
    assign key_out         = out_reg.key;
    assign entry_count_out = out_reg.count;

endmodule

// ===== bench/sorted_key_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core_tb
// Self-checking bench for the sorted key table core.
// ----------------------------------------------------------------------------
// A directed sweep covers the empty table, key extremes, equal keys, the
// duplicate refusal and the bad index and missing key errors. Random phases
// follow: fill, mixed and drain. They push the table to full and back to
// empty several times. A mirror of the table predicts each result. Results
// are compared in order, field by field. Both channels idle and stall at
// random, except in one quiet phase.
// ----------------------------------------------------------------------------
module sorted_key_table_core_tb;

    localparam int           TBL_DEPTH   = 64;
    localparam int           QUIET_LIMIT = 3000;  // cycles with no transfer
    localparam int           DRAIN_TAIL  = 200;   // a little over worst op time
    localparam logic [2:0]   FN_NOP      = 3'd7;  // unused code, no effect
    localparam int           POOL_SIZE   = 10;

    typedef enum int { MODE_FILL, MODE_MIX, MODE_DRAIN } mix_t;

    // one row of the directed sweep; want is used only when typed is set
    typedef struct packed {
        logic [2:0]    op;
        logic [31:0]   k;
        logic [5:0]    ix;
        logic          typed;
        skt_pkg::res_t want;
    } step_t;

    localparam int PLAN_LEN = 25;
    localparam step_t PLAN [0:PLAN_LEN-1] = '{
        // empty table: every lookup fails
        '{skt_pkg::FN_READ, 32'd0, 6'd0, 1'b1, '{skt_pkg::ST_BAD_INDEX, 6'd0, 32'd0, 7'd0}},
        '{skt_pkg::FN_FIND, 32'd5, 6'd0, 1'b1, '{skt_pkg::ST_NOT_FOUND, 6'd0, 32'd0, 7'd0}},
        '{skt_pkg::FN_DEL_IDX, 32'd0, 6'd0, 1'b1, '{skt_pkg::ST_BAD_INDEX, 6'd0, 32'd0, 7'd0}},
        '{skt_pkg::FN_DEL_KEY, 32'd5, 6'd0, 1'b1, '{skt_pkg::ST_NOT_FOUND, 6'd0, 32'd0, 7'd0}},
        '{skt_pkg::FN_DEL_ALL, 32'd5, 6'd0, 1'b1, '{skt_pkg::ST_NOT_FOUND, 6'd0, 32'd0, 7'd0}},
        '{FN_NOP, 32'hFFFF_FFFF, 6'd63, 1'b1, '{skt_pkg::ST_OK, 6'd0, 32'd0, 7'd0}},
        // key extremes, then equal keys land ahead of their peers
        '{skt_pkg::FN_INSERT, 32'd0, 6'd0, 1'b1, '{skt_pkg::ST_OK, 6'd0, 32'd0, 7'd1}},
        '{skt_pkg::FN_INSERT, 32'hFFFF_FFFF, 6'd0, 1'b1, '{skt_pkg::ST_OK, 6'd1, 32'd0, 7'd2}},
        '{skt_pkg::FN_INSERT, 32'd100, 6'd0, 1'b1, '{skt_pkg::ST_OK, 6'd1, 32'd0, 7'd3}},
        '{skt_pkg::FN_INSERT, 32'd100, 6'd0, 1'b1, '{skt_pkg::ST_OK, 6'd1, 32'd0, 7'd4}},
        '{skt_pkg::FN_INSERT, 32'd100, 6'd0, 1'b1, '{skt_pkg::ST_OK, 6'd1, 32'd0, 7'd5}},
        '{skt_pkg::FN_INS_UNIQ, 32'd100, 6'd0, 1'b1, '{skt_pkg::ST_DUPLICATE, 6'd0, 32'd0, 7'd5}},
        '{skt_pkg::FN_INS_UNIQ, 32'd7, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_FIND, 32'd100, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_READ, 32'd0, 6'd5, 1'b0, '0},
        '{skt_pkg::FN_READ, 32'd0, 6'd63, 1'b1, '{skt_pkg::ST_BAD_INDEX, 6'd0, 32'd0, 7'd6}},
        '{skt_pkg::FN_DEL_IDX, 32'd0, 6'd6, 1'b1, '{skt_pkg::ST_BAD_INDEX, 6'd0, 32'd0, 7'd6}},
        '{skt_pkg::FN_INSERT, 32'h8000_0000, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_DEL_KEY, 32'd100, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_DEL_ALL, 32'd100, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_FIND, 32'd100, 6'd0, 1'b1, '{skt_pkg::ST_NOT_FOUND, 6'd0, 32'd0, 7'd4}},
        '{skt_pkg::FN_DEL_ALL, 32'hFFFF_FFFF, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_DEL_IDX, 32'd0, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_READ, 32'd0, 6'd0, 1'b0, '0},
        '{skt_pkg::FN_INS_UNIQ, 32'd0, 6'd0, 1'b0, '0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [skt_pkg::FUNC_W-1:0]    func;
    logic [skt_pkg::KEY_IN_W-1:0]  key;
    logic [skt_pkg::IDX_W-1:0]     index;
    logic                          out_valid;
    logic                          out_stall;
    logic [skt_pkg::STAT_W-1:0]    status;
    logic [skt_pkg::IDX_W-1:0]     found_index;
    logic [skt_pkg::KEY_IN_W-1:0]  key_out;
    logic [skt_pkg::CNT_OUT_W-1:0] entry_count_out;

    // mirror of the table contents, updated as each request transfer happens
    logic [31:0]   mirror_keys [0:TBL_DEPTH-1];
    int            mirror_count;
    skt_pkg::res_t table_replies [$];
    logic [31:0]   key_pool [0:POOL_SIZE-1];
    bit            gaps = 1'b1;
    int            faults;
    int            quiet_cycles;

    sorted_key_table_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .key             (key),
        .index           (index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .found_index     (found_index),
        .key_out         (key_out),
        .entry_count_out (entry_count_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // binary search over the held range, first equal key hit wins
    function automatic int locate(logic [31:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = mirror_count - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (mirror_keys[mid] == k)
                return mid;
            if (mirror_keys[mid] > k)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic void take_out(int pos);
        for (int i = pos; i + 1 < mirror_count; i++)
            mirror_keys[i] = mirror_keys[i + 1];
        mirror_count--;
    endfunction

    // applies one operation to the mirror and returns the reply it earns
    function automatic skt_pkg::res_t table_apply(logic [2:0] op, logic [31:0] k,
                                                  logic [5:0] ix);
        skt_pkg::res_t r;
        int            hit;
        int            pos;
        r        = '0;
        r.status = skt_pkg::ST_OK;
        case (op)
            skt_pkg::FN_INSERT, skt_pkg::FN_INS_UNIQ:
            begin
                if (op == skt_pkg::FN_INS_UNIQ && locate(k) >= 0)
                    r.status = skt_pkg::ST_DUPLICATE;
                else if (mirror_count >= TBL_DEPTH)
                    r.status = skt_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < mirror_count && mirror_keys[pos] < k)
                        pos++;
                    for (int i = mirror_count; i > pos; i--)
                        mirror_keys[i] = mirror_keys[i - 1];
                    mirror_keys[pos] = k;
                    mirror_count++;
                    r.fidx = pos[5:0];
                end
            end
            skt_pkg::FN_FIND:
            begin
                hit = locate(k);
                if (hit < 0)
                    r.status = skt_pkg::ST_NOT_FOUND;
                else
                    r.fidx = hit[5:0];
            end
            skt_pkg::FN_READ:
            begin
                if (ix >= mirror_count)
                    r.status = skt_pkg::ST_BAD_INDEX;
                else
                begin
                    r.fidx = ix;
                    r.key  = mirror_keys[ix];
                end
            end
            skt_pkg::FN_DEL_IDX:
            begin
                if (ix >= mirror_count)
                    r.status = skt_pkg::ST_BAD_INDEX;
                else
                begin
                    take_out(int'(ix));
                    r.fidx = ix;
                end
            end
            skt_pkg::FN_DEL_KEY:
            begin
                hit = locate(k);
                if (hit < 0)
                    r.status = skt_pkg::ST_NOT_FOUND;
                else
                begin
                    take_out(hit);
                    r.fidx = hit[5:0];
                end
            end
            skt_pkg::FN_DEL_ALL:
            begin
                hit = locate(k);
                if (hit < 0)
                    r.status = skt_pkg::ST_NOT_FOUND;
                else
                begin
                    // walk back to the lowest equal key, then strip the run
                    pos = hit;
                    while (pos > 0 && mirror_keys[pos - 1] == k)
                        pos--;
                    while (pos < mirror_count && mirror_keys[pos] == k)
                        take_out(pos);
                    r.fidx = pos[5:0];
                end
            end
            default:
                ;
        endcase
        r.count = mirror_count[6:0];
        return r;
    endfunction

    function automatic logic [2:0] pick_op(mix_t mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:
                return (r < 55) ? skt_pkg::FN_INSERT  : (r < 75) ? skt_pkg::FN_INS_UNIQ :
                       (r < 82) ? skt_pkg::FN_FIND    : (r < 88) ? skt_pkg::FN_READ     :
                       (r < 92) ? skt_pkg::FN_DEL_IDX :
                       (r < 96) ? skt_pkg::FN_DEL_KEY : skt_pkg::FN_DEL_ALL;
            MODE_DRAIN:
                return (r < 10) ? skt_pkg::FN_INSERT  : (r < 15) ? skt_pkg::FN_INS_UNIQ :
                       (r < 22) ? skt_pkg::FN_FIND    : (r < 30) ? skt_pkg::FN_READ     :
                       (r < 55) ? skt_pkg::FN_DEL_IDX :
                       (r < 80) ? skt_pkg::FN_DEL_KEY : skt_pkg::FN_DEL_ALL;
            default:
                return (r < 3) ? FN_NOP : 3'($urandom_range(6));
        endcase
    endfunction

    // keys mostly from a small pool or the table itself, so equal keys pile up
    function automatic logic [31:0] pick_key(logic [2:0] op);
        int r;
        r = $urandom_range(99);
        if (mirror_count > 0 && op != skt_pkg::FN_INSERT && r < 50)
            return mirror_keys[$urandom_range(mirror_count - 1)];
        if (r < 80)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic logic [5:0] pick_index();
        if (mirror_count > 0 && $urandom_range(99) < 75)
            return 6'($urandom_range(mirror_count - 1));
        return 6'($urandom_range(63));
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
        faults++;
    endtask

    // drives one request, holds it until the transfer, then books the reply
    task automatic issue(logic [2:0] op, logic [31:0] k, logic [5:0] ix,
                         logic typed, skt_pkg::res_t want);
        skt_pkg::res_t model;
        while (gaps && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        index    <= ix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model = table_apply(op, k, ix);
        table_replies.push_back(typed ? want : model);
    endtask

    // result side: random stall, in-order compare against the booked replies
    always @(posedge clk)
    begin : result_check
        skt_pkg::res_t want;
        out_stall <= gaps && ($urandom_range(99) < 28);
        if (out_valid && !out_stall)
        begin
            if (table_replies.size() == 0)
                report("result with nothing pending, status", 32'(status), 0);
            else
            begin
                want = table_replies.pop_front();
                if (status !== want.status)
                    report("status", 32'(status), 32'(want.status));
                if (found_index !== want.fidx)
                    report("found_index", 32'(found_index), 32'(want.fidx));
                if (key_out !== want.key)
                    report("key_out", key_out, want.key);
                if (entry_count_out !== want.count)
                    report("entry_count_out", 32'(entry_count_out), 32'(want.count));
            end
        end
    end

    // watchdog: a long run of cycles with no transfer on either side is a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        mix_t       mode;
        logic [2:0] op;
        in_valid     <= 1'b0;
        func         <= '0;
        key          <= '0;
        index        <= '0;
        out_stall    <= 1'b0;
        rst_n        <= 1'b0;
        faults       = 0;
        quiet_cycles = 0;
        mirror_count = 0;
        key_pool[0]  = 32'd0;
        key_pool[1]  = 32'hFFFF_FFFF;
        key_pool[2]  = 32'd1;
        key_pool[3]  = 32'h8000_0000;
        key_pool[4]  = 32'h7FFF_FFFF;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
            issue(PLAN[i].op, PLAN[i].k, PLAN[i].ix, PLAN[i].typed, PLAN[i].want);

        // three rounds of fill, mix, drain; the sender waits for every reply
        // before each phase, and the middle mix phase runs with no idling
        for (int round = 0; round < 3; round++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                mode = mix_t'(m);
                in_valid <= 1'b0;
                @(posedge clk);
                while (table_replies.size() != 0)
                    @(posedge clk);
                gaps = !(round == 1 && mode == MODE_MIX);
                for (int n = 0; n < ((mode == MODE_MIX) ? 180 : 160); n++)
                begin
                    op = pick_op(mode);
                    issue(op, pick_key(op), pick_index(), 1'b0, '0);
                end
            end
        end
        gaps = 1'b1;

        in_valid <= 1'b0;
        @(posedge clk);
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (faults == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
